>>> design/pms_pkg.sv
// ----------------------------------------------------------------------------
// pms_pkg
// Shared types and constants of the periodic message scheduler.
// ----------------------------------------------------------------------------
package pms_pkg;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_REGISTERED = 2'd0,
      KIND_FULL       = 2'd1,
      KIND_DUE        = 2'd2,
      KIND_NONE       = 2'd3
   } kind_type;

   // Input item functions
   localparam logic FUNC_REGISTER = 1'b0;
   localparam logic FUNC_TICK     = 1'b1;

   // Control register reset value and byte-address select bit value
   localparam logic [7:0] STAGGER_RESET = 8'd2;
   localparam logic       REG_STAGGER   = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept_reg;   // register item accepted
      logic accept_tick;  // tick item accepted
      logic scan;         // scan in progress
      logic step;         // evaluate the current entry and advance
      logic finish;       // load the closing result of a tick
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic out_free;     // result register can take a new item
      logic count_zero;   // table is empty
      logic due;          // current entry is due
      logic pend_valid;   // a due result is held back
      logic at_last;      // current entry is the last one in the table
   } status_type;

endpackage

>>> design/pms_controller.sv
// ----------------------------------------------------------------------------
// pms_controller
// Sequencer for register items and tick scans.
// ----------------------------------------------------------------------------
module pms_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_func,
   output logic                req_stall,
   input  pms_pkg::status_type status,
   output pms_pkg::cmd_type    cmd
);
   import pms_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = !status.out_free;
            if (req_valid && status.out_free) begin
               if (req_func == FUNC_REGISTER) begin
                  cmd.accept_reg = 1'b1;
               end else begin
                  cmd.accept_tick = 1'b1;
                  if (!status.count_zero) begin
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            // hold when a held-back result must go out and the output is busy
            cmd.step = !(status.due && status.pend_valid && !status.out_free);
            if (cmd.step && status.at_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_step_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> state_ff == ST_SCAN)
      else $error("step outside scan");

   a_scan_leaves_to_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && state_in != ST_SCAN) |=> state_ff == ST_FINISH)
      else $error("scan did not end in finish");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall)
      else $error("input taken during a scan");

endmodule

>>> design/pms_datapath.sv
// ----------------------------------------------------------------------------
// pms_datapath
// Entry table memory, scan index, due check and result register.
// ----------------------------------------------------------------------------
module pms_datapath #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  pms_pkg::cmd_type    cmd,
   output pms_pkg::status_type status,
   input  logic [7:0]          stagger_ms,
   input  logic [31:0]         req_now_ms,
   input  logic [7:0]          req_msg_id,
   input  logic [15:0]         req_period,
   input  logic                req_enabled,
   input  logic                req_has_packer,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_due_id,
   output logic                rsp_last
);
   import pms_pkg::*;

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef struct packed {
      logic [7:0]  ident;
      logic        enabled;
      logic        packer;
      logic [15:0] period;
      logic [31:0] stamp;
   } entry_type;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_ff;
   entry_type wr_data;
   logic      wr_en;
   logic [IW-1:0] wr_addr, rd_addr;

   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [31:0]   now_ff;
   logic          pend_valid_ff, pend_valid_in;
   logic [7:0]    pend_id_ff, pend_id_in;

   logic          rsp_valid_ff, rsp_valid_in;
   kind_type      kind_ff, kind_in;
   logic [7:0]    due_id_ff, due_id_in;
   logic          last_ff, last_in;

   logic          full, load;
   logic [CW+7:0] offset;
   logic [31:0]   diff;

   assign full   = count_ff == CW'(TABLE_DEPTH);
   assign offset = count_ff * stagger_ms;
   assign diff   = now_ff - rd_ff.stamp;

   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign status.count_zero = count_ff == '0;
   assign status.due        = rd_ff.enabled && rd_ff.packer && !diff[31] &&
                              (diff >= {16'd0, rd_ff.period});
   assign status.pend_valid = pend_valid_ff;
   assign status.at_last    = (CW'(idx_ff) + CW'(1)) == count_ff;

   // Table port selection
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = rd_ff;
      if (cmd.accept_reg) begin
         wr_en   = !full;
         wr_addr = count_ff[IW-1:0];
         wr_data = '{ident:   req_msg_id,
                     enabled: req_enabled,
                     packer:  req_has_packer,
                     period:  req_period,
                     stamp:   req_now_ms + 32'(offset)};
      end else if (cmd.step && status.due) begin
         wr_en         = 1'b1;
         wr_data.stamp = now_ff;
      end
      if (!cmd.scan) begin
         rd_addr = '0;
      end else if (cmd.step) begin
         rd_addr = status.at_last ? '0 : idx_ff + IW'(1);
      end else begin
         rd_addr = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   // Scan bookkeeping and result register
   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      kind_in       = kind_ff;
      due_id_in     = due_id_ff;
      last_in       = last_ff;
      load          = 1'b0;
      if (cmd.accept_reg) begin
         load      = 1'b1;
         kind_in   = full ? KIND_FULL : KIND_REGISTERED;
         due_id_in = '0;
         last_in   = 1'b1;
         if (!full) begin
            count_in = count_ff + CW'(1);
         end
      end
      if (cmd.accept_tick) begin
         idx_in        = '0;
         pend_valid_in = 1'b0;
         if (status.count_zero) begin
            load      = 1'b1;
            kind_in   = KIND_NONE;
            due_id_in = '0;
            last_in   = 1'b1;
         end
      end
      if (cmd.step) begin
         idx_in = idx_ff + IW'(1);
         if (status.due) begin
            if (pend_valid_ff) begin
               load      = 1'b1;
               kind_in   = KIND_DUE;
               due_id_in = pend_id_ff;
               last_in   = 1'b0;
            end
            pend_valid_in = 1'b1;
            pend_id_in    = rd_ff.ident;
         end
      end
      if (cmd.finish) begin
         load      = 1'b1;
         kind_in   = pend_valid_ff ? KIND_DUE : KIND_NONE;
         due_id_in = pend_valid_ff ? pend_id_ff : 8'd0;
         last_in   = 1'b1;
      end
      rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      idx_ff     <= idx_in;
      pend_id_ff <= pend_id_in;
      kind_ff    <= kind_in;
      due_id_ff  <= due_id_in;
      last_ff    <= last_in;
      if (cmd.accept_tick) begin
         now_ff <= req_now_ms;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_due_id = due_id_ff;
   assign rsp_last   = last_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      load |-> status.out_free)
      else $error("result overwritten before delivery");

   a_full_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept_reg && full) |=> $stable(count_ff))
      else $error("full table changed count");

endmodule

>>> design/periodic_message_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_message_scheduler
// Table of periodic messages with staggered registration and tick scans.
// ----------------------------------------------------------------------------
// Register item: one result, registered and valid in the cycle after acceptance; the next
//   item can be taken in the following cycle unless the result channel stalls.
// Tick item: the scan reads one table entry per cycle from a memory with a
//   registered read port, unless a held-back result meets a stalled output.
// Reset clears the entry count, the scan controller and the result valid;
//   stagger_ms returns to 2. Table contents are not cleared.
// ----------------------------------------------------------------------------
module periodic_message_scheduler #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [31:0] req_now_ms,
   input  logic [7:0]  req_msg_id,
   input  logic [15:0] req_period,
   input  logic        req_enabled,
   input  logic        req_has_packer,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_due_id,
   output logic        rsp_last,
   // control register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import pms_pkg::*;

   cmd_type    cmd;
   status_type status;

   logic [7:0] stagger_ff, stagger_in;
   logic       csr_hit;

   // The single register sits at byte offset zero; bit 2 picks the next
   // register slot, which does not exist.
   assign csr_hit    = csr_paddr[2] == REG_STAGGER;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? {24'd0, stagger_ff} : 32'd0;

   // Write on the access phase of a write transfer.
   always_comb begin
      stagger_in = stagger_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         stagger_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stagger_ff <= STAGGER_RESET;
      end else begin
         stagger_ff <= stagger_in;
      end
   end

   // Sequencer: takes items, walks the table on a tick, closes the result list.
   pms_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: table memory, due check, held-back result for the last flag.
   pms_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .stagger_ms     (stagger_ff),
      .req_now_ms     (req_now_ms),
      .req_msg_id     (req_msg_id),
      .req_period     (req_period),
      .req_enabled    (req_enabled),
      .req_has_packer (req_has_packer),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_due_id     (rsp_due_id),
      .rsp_last       (rsp_last)
   );

endmodule
